>>> rtl/dsss_pkg.sv
package dsss_pkg;

   // Nucleotide codes
   localparam logic [2:0] BASE_A = 3'd0;
   localparam logic [2:0] BASE_C = 3'd1;
   localparam logic [2:0] BASE_G = 3'd2;
   localparam logic [2:0] BASE_T = 3'd3;
   localparam logic [2:0] BASE_N = 3'd4;

   // Site kinds, also the release order inside one anchor
   localparam logic [2:0] KIND_DIR_START    = 3'd0;
   localparam logic [2:0] KIND_DIR_DONOR    = 3'd1;
   localparam logic [2:0] KIND_DIR_STOP     = 3'd2;
   localparam logic [2:0] KIND_DIR_ACCEPTOR = 3'd3;
   localparam logic [2:0] KIND_REV_ACCEPTOR = 3'd4;
   localparam logic [2:0] KIND_REV_DONOR    = 3'd5;
   localparam logic [2:0] KIND_REV_STOP     = 3'd6;
   localparam logic [2:0] KIND_REV_START    = 3'd7;

   // Register indexes of the configuration port
   localparam int CSR_INDEX_WIDTH = 3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GC_DONOR_ENABLE = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TAA_ENABLE      = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TAG_ENABLE      = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TGA_ENABLE      = 3'd3;

   // Widths
   localparam int POS_WIDTH_DEFAULT = 32;
   localparam int SITE_POS_WIDTH    = 32;
   localparam int REQ_DATA_WIDTH    = 8;
   localparam int RSP_DATA_WIDTH    = 40;
   localparam int KINDS             = 8;
   localparam int ANCHORS           = 3;
   localparam int JOB_BITS          = KINDS * ANCHORS;
   localparam int JOB_IDX_WIDTH     = $clog2(JOB_BITS);

   // Per kind: splice sites give three records, one per phase
   localparam logic [KINDS-1:0] KIND_IS_SPLICE = 8'b0011_1010;
   // Per kind: frame offset added to the anchor residue
   localparam logic [KINDS-1:0] KIND_BASE_OFF  = 8'b1010_1100;

   typedef logic [JOB_BITS-1:0] job_flags_type;

   // Frame step per phase for a kind
   function automatic logic [1:0] kind_step(input logic [2:0] kind);
      logic [1:0] step;
      case (kind)
         KIND_DIR_DONOR, KIND_DIR_ACCEPTOR: step = 2'd2;
         KIND_REV_ACCEPTOR, KIND_REV_DONOR: step = 2'd1;
         default:                           step = 2'd0;
      endcase
      return step;
   endfunction

   // Residue modulo three of a small value
   function automatic logic [1:0] mod3(input logic [2:0] value);
      logic [1:0] res;
      case (value)
         3'd0, 3'd3, 3'd6: res = 2'd0;
         3'd1, 3'd4, 3'd7: res = 2'd1;
         default:          res = 2'd2;
      endcase
      return res;
   endfunction

endpackage

>>> rtl/dna_signal_site_scanner.sv
// Splice site and codon scanner for a nucleotide stream.
// req channel: one base per beat, tdata[2:0] is the base code (A C G T, any
// other code unknown), tlast marks the final base of a sequence.
// rsp channel: one site record per beat; tdata holds position, frame and
// phase, tuser the site kind, tlast marks the final record released by one
// base. Records come in anchor position order, then kind order, then phase.
// Csr port: write enable, register index and one data bit, taken at once.
// The records of an accepted base pass the job register, then the output
// register.
// A base that releases no record is taken every cycle; a base that releases
// records occupies the record emitter, one record per cycle unless the
// receiver stalls, and the next base is taken in the cycle its last record
// moves to the output register.
// When the receiver stalls, the output register holds its record and the
// emitter waits; req_tready drops once the pending records cannot move.
// Reset clears the sequence state, pending sites, emitter and output valid,
// and loads the register defaults (GC donor off, all stop codons on).
// After a base with tlast the sequence state returns to reset values.
module dna_signal_site_scanner #(
   parameter int POS_WIDTH = dsss_pkg::POS_WIDTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // [2:0] base, [7:3] zero
   input  logic [dsss_pkg::REQ_DATA_WIDTH-1:0]   req_tdata,
   input  logic                                  req_tlast,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [31:0] site_position, [33:32] reading_frame, [35:34] phase, [39:36] zero
   output logic [dsss_pkg::RSP_DATA_WIDTH-1:0]   rsp_tdata,
   // [2:0] site_kind
   output logic [2:0]                            rsp_tuser,
   output logic                                  rsp_tlast,
   input  logic                                  csr_we,
   input  logic [dsss_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic                                  csr_wdata
);

   localparam int WIDE = 64;
   localparam logic [POS_WIDTH-1:0] POS_MAX = {POS_WIDTH{1'b1}};

   // Configuration registers
   logic gc_en_ff, taa_en_ff, tag_en_ff, tga_en_ff;

   // Sequence state
   logic [2:0]           b1_ff, b2_ff;
   logic [POS_WIDTH-1:0] cnt_ff, cnt_in;
   logic [1:0]           mod_ff, mod_in;
   logic [7:0]           pend0_ff, pend1_ff;

   // Emitter job
   dsss_pkg::job_flags_type job_flags_ff, job_flags_in;
   logic [POS_WIDTH-1:0]    job_cnt_ff;
   logic [1:0]              job_mod_ff;
   logic [1:0]              phase_ff, phase_in;

   // Output register
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [dsss_pkg::SITE_POS_WIDTH-1:0] rsp_pos_ff;
   logic [1:0]                         rsp_frame_ff, rsp_phase_ff;
   logic [2:0]                         rsp_kind_ff;
   logic                               rsp_last_ff;

   logic       accept, pop, job_any, hold_bit, rec_last, is_splice;
   logic [2:0] b0;
   logic [7:0] f_old, f_mid, f_new;
   dsss_pkg::job_flags_type flags_pop;
   logic [dsss_pkg::JOB_IDX_WIDTH-1:0] sel_idx;
   logic [1:0]           sel_anchor;
   logic [2:0]           sel_kind;
   logic [POS_WIDTH-1:0] anchor_pos;
   logic [WIDE-1:0]      anchor_wide;
   logic [1:0]           amod, frame;
   logic [3:0]           step_prod;

   // Write configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         gc_en_ff  <= 1'b0;
         taa_en_ff <= 1'b1;
         tag_en_ff <= 1'b1;
         tga_en_ff <= 1'b1;
      end else if (csr_we) begin
         case (csr_index)
            dsss_pkg::CSR_GC_DONOR_ENABLE: gc_en_ff  <= csr_wdata;
            dsss_pkg::CSR_TAA_ENABLE:      taa_en_ff <= csr_wdata;
            dsss_pkg::CSR_TAG_ENABLE:      tag_en_ff <= csr_wdata;
            dsss_pkg::CSR_TGA_ENABLE:      tga_en_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Detect sites on the incoming base and the two before it
   always_comb begin
      b0 = (req_tdata[2:0] > dsss_pkg::BASE_N) ? dsss_pkg::BASE_N : req_tdata[2:0];
      f_old = pend0_ff;
      f_mid = pend1_ff;
      f_new = 8'd0;
      if (b1_ff == dsss_pkg::BASE_G &&
          (b0 == dsss_pkg::BASE_T || (gc_en_ff && b0 == dsss_pkg::BASE_C)))
         f_mid[dsss_pkg::KIND_DIR_DONOR] = 1'b1;
      if (b1_ff == dsss_pkg::BASE_C && b0 == dsss_pkg::BASE_T)
         f_mid[dsss_pkg::KIND_REV_ACCEPTOR] = 1'b1;
      if (b1_ff == dsss_pkg::BASE_A && b0 == dsss_pkg::BASE_G)
         f_new[dsss_pkg::KIND_DIR_ACCEPTOR] = 1'b1;
      if ((b1_ff == dsss_pkg::BASE_A && b0 == dsss_pkg::BASE_C) ||
          (gc_en_ff && b1_ff == dsss_pkg::BASE_G && b0 == dsss_pkg::BASE_C))
         f_new[dsss_pkg::KIND_REV_DONOR] = 1'b1;
      if (b2_ff == dsss_pkg::BASE_A && b1_ff == dsss_pkg::BASE_T && b0 == dsss_pkg::BASE_G)
         f_old[dsss_pkg::KIND_DIR_START] = 1'b1;
      if ((taa_en_ff && b2_ff == dsss_pkg::BASE_T && b1_ff == dsss_pkg::BASE_A &&
           b0 == dsss_pkg::BASE_A) ||
          (tag_en_ff && b2_ff == dsss_pkg::BASE_T && b1_ff == dsss_pkg::BASE_A &&
           b0 == dsss_pkg::BASE_G) ||
          (tga_en_ff && b2_ff == dsss_pkg::BASE_T && b1_ff == dsss_pkg::BASE_G &&
           b0 == dsss_pkg::BASE_A))
         f_new[dsss_pkg::KIND_DIR_STOP] = 1'b1;
      if (b2_ff == dsss_pkg::BASE_C && b1_ff == dsss_pkg::BASE_A && b0 == dsss_pkg::BASE_T)
         f_new[dsss_pkg::KIND_REV_START] = 1'b1;
      if ((taa_en_ff && b2_ff == dsss_pkg::BASE_T && b1_ff == dsss_pkg::BASE_T &&
           b0 == dsss_pkg::BASE_A) ||
          (tag_en_ff && b2_ff == dsss_pkg::BASE_C && b1_ff == dsss_pkg::BASE_T &&
           b0 == dsss_pkg::BASE_A) ||
          (tga_en_ff && b2_ff == dsss_pkg::BASE_T && b1_ff == dsss_pkg::BASE_C &&
           b0 == dsss_pkg::BASE_A))
         f_old[dsss_pkg::KIND_REV_STOP] = 1'b1;
   end

   // Pick the lowest pending record: anchor first, then kind
   always_comb begin
      sel_idx = '0;
      for (int i = dsss_pkg::JOB_BITS - 1; i >= 0; i--) begin
         if (job_flags_ff[i]) sel_idx = dsss_pkg::JOB_IDX_WIDTH'(i);
      end
   end

   assign job_any    = |job_flags_ff;
   assign sel_anchor = sel_idx[4:3];
   assign sel_kind   = sel_idx[2:0];
   assign is_splice  = dsss_pkg::KIND_IS_SPLICE[sel_kind];
   assign hold_bit   = is_splice && (phase_ff != 2'd2);
   assign flags_pop  = hold_bit ? job_flags_ff
                                : (job_flags_ff & ~(dsss_pkg::job_flags_type'(1) << sel_idx));
   assign rec_last   = (flags_pop == '0);

   assign pop        = job_any && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !job_any || (pop && rec_last);
   assign accept     = req_tvalid && req_tready;

   // Build the fields of the selected record
   always_comb begin
      case (sel_anchor)
         2'd0: begin
            anchor_pos = (job_cnt_ff >= POS_WIDTH'(2)) ? job_cnt_ff - POS_WIDTH'(2) : '0;
            amod       = dsss_pkg::mod3({1'b0, job_mod_ff} + 3'd1);
         end
         2'd1: begin
            anchor_pos = (job_cnt_ff >= POS_WIDTH'(1)) ? job_cnt_ff - POS_WIDTH'(1) : '0;
            amod       = dsss_pkg::mod3({1'b0, job_mod_ff} + 3'd2);
         end
         default: begin
            anchor_pos = job_cnt_ff;
            amod       = job_mod_ff;
         end
      endcase
      anchor_wide = {{(WIDE - POS_WIDTH){1'b0}}, anchor_pos};
      step_prod   = {2'b00, phase_ff} * {2'b00, dsss_pkg::kind_step(sel_kind)};
      frame       = dsss_pkg::mod3({1'b0, amod} +
                                   {2'b00, dsss_pkg::KIND_BASE_OFF[sel_kind]} +
                                   step_prod[2:0]);
   end

   // Advance the sequence state on an accepted base
   always_comb begin
      cnt_in = (cnt_ff < POS_MAX) ? cnt_ff + POS_WIDTH'(1) : cnt_ff;
      mod_in = dsss_pkg::mod3({1'b0, mod_ff} + 3'd1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_ff    <= dsss_pkg::BASE_N;
         b2_ff    <= dsss_pkg::BASE_N;
         cnt_ff   <= '0;
         mod_ff   <= 2'd0;
         pend0_ff <= 8'd0;
         pend1_ff <= 8'd0;
      end else if (accept) begin
         if (req_tlast) begin
            b1_ff    <= dsss_pkg::BASE_N;
            b2_ff    <= dsss_pkg::BASE_N;
            cnt_ff   <= '0;
            mod_ff   <= 2'd0;
            pend0_ff <= 8'd0;
            pend1_ff <= 8'd0;
         end else begin
            b1_ff    <= b0;
            b2_ff    <= b1_ff;
            cnt_ff   <= cnt_in;
            mod_ff   <= mod_in;
            pend0_ff <= f_mid;
            pend1_ff <= f_new;
         end
      end
   end

   // Load a new job on accept, else retire one record per pop
   always_comb begin
      job_flags_in = job_flags_ff;
      phase_in     = phase_ff;
      if (accept) begin
         job_flags_in = req_tlast ? {f_new, f_mid, f_old} : {8'd0, 8'd0, f_old};
         phase_in     = 2'd0;
      end else if (pop) begin
         job_flags_in = flags_pop;
         phase_in     = hold_bit ? phase_ff + 2'd1 : 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_flags_ff <= '0;
         phase_ff     <= 2'd0;
      end else begin
         job_flags_ff <= job_flags_in;
         phase_ff     <= phase_in;
      end
   end

   // Hold the anchor base of the job
   always_ff @(posedge clock) begin
      if (accept) begin
         job_cnt_ff <= cnt_ff;
         job_mod_ff <= mod_ff;
      end
   end

   // Output register: load on pop, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop)             rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_pos_ff   <= anchor_wide[dsss_pkg::SITE_POS_WIDTH-1:0];
         rsp_kind_ff  <= sel_kind;
         rsp_frame_ff <= frame;
         rsp_phase_ff <= is_splice ? phase_ff : 2'd0;
         rsp_last_ff  <= rec_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_phase_ff, rsp_frame_ff, rsp_pos_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
